FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define AST_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent, both sampled on the rising edge
`define AST_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/crmt_pkg.sv
// shared types and constants of the clamped rectangle map transfer block
`default_nettype none

package crmt_pkg;

	localparam int MAX_WIDTH_DEF  = 128;
	localparam int MAX_HEIGHT_DEF = 128;
	localparam int LAYERS_DEF     = 4;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	// input item codes
	localparam logic [1:0] OP_EXTRACT = 2'd0;
	localparam logic [1:0] OP_INSERT  = 2'd1;
	localparam logic [1:0] OP_WRITE   = 2'd2;
	localparam logic [1:0] OP_READ    = 2'd3;

	// store selection
	localparam logic [1:0] KIND_HEIGHT = 2'd0;
	localparam logic [1:0] KIND_LAYER  = 2'd1;
	localparam logic [1:0] KIND_EDGE   = 2'd2;

	// register word index on the config port
	localparam logic [2:0] REG_RECT_LEFT   = 3'd0;
	localparam logic [2:0] REG_RECT_TOP    = 3'd1;
	localparam logic [2:0] REG_RECT_RIGHT  = 3'd2;
	localparam logic [2:0] REG_RECT_BOTTOM = 3'd3;
	localparam logic [2:0] REG_MAP_WIDTH   = 3'd4;
	localparam logic [2:0] REG_MAP_HEIGHT  = 3'd5;
	localparam logic [2:0] REG_MAP_KIND    = 3'd6;
	localparam logic [2:0] REG_LAYER_SEL   = 3'd7;

	localparam logic [7:0] BYTE_FULL = 8'd255;

	// how the result word is formed from the memory read data
	typedef enum logic [2:0] {
		DSEL_ZERO,
		DSEL_WORD,
		DSEL_BYTE,
		DSEL_LAYER,
		DSEL_EDGE
	} dout_sel_t;

endpackage

`default_nettype wire

FILE: hw/rtl/crmt_ram.sv
// generic single-port ram with registered read
`default_nettype none

module crmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read data holds while the port is not enabled
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/clamped_rect_map_transfer.sv
// Clamped rectangle map transfer. A cursor walks the configured rectangle
// [rect_left, rect_right) x [rect_top, rect_bottom) row by row, one element for
// each extract (opcode 0) or insert (opcode 1) item; extract reads the chosen
// store with the coordinates clamped to the map, insert writes only inside the
// map. Opcodes 2 and 3 write and read raw cells at (cell_x, cell_y). The height
// map sits in a 16-bit ram, the layer masks and the edge map share one 8-bit
// ram, each layer region padded to a power of two. One item is taken every
// cycle unless the input stalls; its result passes from the read stage, which
// waits on the registered read of the single-port rams, into the output
// register. The input stalls only while both the read stage and the output
// register hold items and the output is not taken. The stores are not
// cleared: a cell must be written before it is read. Any register write sends
// the cursor back to the rectangle origin; write registers only while the
// block is idle.
`default_nettype none

module clamped_rect_map_transfer
	import crmt_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int LAYERS     = LAYERS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// config port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	// input items
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [31:0]        s_tdata,  // data_in[15:0], cell_x[22:16], cell_y[29:23]
	input  wire logic [1:0]         s_tuser,  // opcode[1:0]
	// result items
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic      [15:0]        m_tdata,  // data_out[15:0]
	output logic                    m_tlast,
	output logic      [0:0]         m_tuser   // stored[0]
);

	localparam int CELLS   = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW      = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int LW      = $clog2(LAYERS + 1);
	localparam int BDEPTH  = (LAYERS + 1) * (2 ** AW);
	localparam int BAW     = LW + AW;

	// config registers
	logic signed [8:0] rect_left_q, rect_top_q, rect_right_q, rect_bottom_q;
	logic [7:0]        map_width_q, map_height_q;
	logic [1:0]        map_kind_q, layer_sel_q;

	logic signed [8:0] cur_col_q, cur_row_q;

	logic       cfg_wr;
	logic [2:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_left_q   <= '0;
			rect_top_q    <= '0;
			rect_right_q  <= 9'sd1;
			rect_bottom_q <= 9'sd1;
			map_width_q   <= 8'd128;
			map_height_q  <= 8'd128;
			map_kind_q    <= KIND_HEIGHT;
			layer_sel_q   <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_RECT_LEFT:   rect_left_q   <= pwdata[8:0];
				REG_RECT_TOP:    rect_top_q    <= pwdata[8:0];
				REG_RECT_RIGHT:  rect_right_q  <= pwdata[8:0];
				REG_RECT_BOTTOM: rect_bottom_q <= pwdata[8:0];
				REG_MAP_WIDTH:   map_width_q   <= pwdata[7:0];
				REG_MAP_HEIGHT:  map_height_q  <= pwdata[7:0];
				REG_MAP_KIND:    map_kind_q    <= pwdata[1:0];
				REG_LAYER_SEL:   layer_sel_q   <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_RECT_LEFT:   prdata = {23'd0, rect_left_q};
			REG_RECT_TOP:    prdata = {23'd0, rect_top_q};
			REG_RECT_RIGHT:  prdata = {23'd0, rect_right_q};
			REG_RECT_BOTTOM: prdata = {23'd0, rect_bottom_q};
			REG_MAP_WIDTH:   prdata = {24'd0, map_width_q};
			REG_MAP_HEIGHT:  prdata = {24'd0, map_height_q};
			REG_MAP_KIND:    prdata = {30'd0, map_kind_q};
			REG_LAYER_SEL:   prdata = {30'd0, layer_sel_q};
			default:         prdata = '0;
		endcase
	end

	// effective map size and layer
	logic [7:0]    eff_w, eff_h;
	logic [LW-1:0] lay_eff;

	always_comb begin
		eff_w = map_width_q;
		if (map_width_q == 8'd0) begin
			eff_w = 8'd1;
		end else if (32'(map_width_q) > MAX_WIDTH) begin
			eff_w = 8'(MAX_WIDTH);
		end
		eff_h = map_height_q;
		if (map_height_q == 8'd0) begin
			eff_h = 8'd1;
		end else if (32'(map_height_q) > MAX_HEIGHT) begin
			eff_h = 8'(MAX_HEIGHT);
		end
		if (32'(layer_sel_q) >= LAYERS) begin
			lay_eff = LW'(LAYERS - 1);
		end else begin
			lay_eff = LW'(layer_sel_q);
		end
	end

	// item fields
	logic        acc;
	logic [1:0]  opcode;
	logic [15:0] data_in;
	logic [6:0]  cell_x, cell_y;

	assign acc     = s_tvalid && s_tready;
	assign opcode  = s_tuser;
	assign data_in = s_tdata[15:0];
	assign cell_x  = s_tdata[22:16];
	assign cell_y  = s_tdata[29:23];

	// cursor arithmetic in 10-bit signed
	logic signed [9:0] xs, ys, ws, hs, wm1, hm1;
	logic signed [9:0] lft, top, rgt, bot, nx, ny;
	logic              rect_empty, wrap, cur_inside, cell_inside, kind_ok, is_direct;
	logic [7:0]        rx, ry, col_sel, row_sel;
	logic [15:0]       idx;
	logic              access, wr_op;
	logic [7:0]        byte_wdata;
	dout_sel_t         dsel;

	always_comb begin
		xs  = {cur_col_q[8], cur_col_q};
		ys  = {cur_row_q[8], cur_row_q};
		lft = {rect_left_q[8], rect_left_q};
		top = {rect_top_q[8], rect_top_q};
		rgt = {rect_right_q[8], rect_right_q};
		bot = {rect_bottom_q[8], rect_bottom_q};
		ws  = {2'b00, eff_w};
		hs  = {2'b00, eff_h};
		wm1 = ws - 10'sd1;
		hm1 = hs - 10'sd1;

		rect_empty = (rgt <= lft) || (bot <= top);
		kind_ok    = (map_kind_q == KIND_HEIGHT) || (map_kind_q == KIND_LAYER)
			|| (map_kind_q == KIND_EDGE);
		is_direct  = (opcode == OP_WRITE) || (opcode == OP_READ);

		// clamp for extract
		if (xs[9]) begin
			rx = 8'd0;
		end else if (xs > wm1) begin
			rx = wm1[7:0];
		end else begin
			rx = xs[7:0];
		end
		if (ys[9]) begin
			ry = 8'd0;
		end else if (ys > hm1) begin
			ry = hm1[7:0];
		end else begin
			ry = ys[7:0];
		end

		cur_inside  = !xs[9] && (xs < ws) && !ys[9] && (ys < hs);
		cell_inside = ({1'b0, cell_x} < eff_w) && ({1'b0, cell_y} < eff_h);

		// cursor step
		nx = xs + 10'sd1;
		ny = ys;
		if (nx >= rgt) begin
			nx = lft;
			ny = ys + 10'sd1;
		end
		wrap = (ny >= bot) || (ny < top);

		// address of the touched cell
		if (is_direct) begin
			col_sel = {1'b0, cell_x};
			row_sel = {1'b0, cell_y};
		end else begin
			col_sel = rx;
			row_sel = ry;
		end
		idx = 16'(col_sel) + 16'(row_sel) * 16'(eff_w);

		wr_op  = (opcode == OP_WRITE) || (opcode == OP_INSERT);
		access = 1'b0;
		dsel   = DSEL_ZERO;
		case (opcode)
			OP_WRITE: access = cell_inside;
			OP_READ: begin
				access = cell_inside;
				if (cell_inside && kind_ok) begin
					dsel = (map_kind_q == KIND_HEIGHT) ? DSEL_WORD : DSEL_BYTE;
				end
			end
			OP_EXTRACT: begin
				access = !rect_empty;
				if (!rect_empty) begin
					case (map_kind_q)
						KIND_HEIGHT: dsel = DSEL_WORD;
						KIND_LAYER:  dsel = DSEL_LAYER;
						KIND_EDGE:   dsel = DSEL_EDGE;
						default:     dsel = DSEL_ZERO;
					endcase
				end
			end
			OP_INSERT: access = !rect_empty && cur_inside;
			default: access = 1'b0;
		endcase

		if (opcode == OP_WRITE) begin
			byte_wdata = data_in[7:0];
		end else if (map_kind_q == KIND_LAYER) begin
			byte_wdata = data_in[15:8];
		end else begin
			byte_wdata = (data_in != 16'd0) ? BYTE_FULL : 8'd0;
		end
	end

	// memories
	logic             word_en, byte_en;
	logic [AW-1:0]    word_addr;
	logic [LW-1:0]    region;
	logic [BAW-1:0]   byte_addr;
	logic [15:0]      word_rdata;
	logic [7:0]       byte_rdata;

	assign word_en   = acc && access && (map_kind_q == KIND_HEIGHT);
	assign byte_en   = acc && access
		&& ((map_kind_q == KIND_LAYER) || (map_kind_q == KIND_EDGE));
	assign word_addr = AW'(idx);
	assign region    = (map_kind_q == KIND_EDGE) ? LW'(LAYERS) : lay_eff;
	assign byte_addr = {region, AW'(idx)};

	crmt_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_word_ram (
		.clk  (clk),
		.en   (word_en),
		.we   (wr_op),
		.addr (word_addr),
		.wdata(data_in),
		.rdata(word_rdata)
	);

	crmt_ram #(
		.WIDTH(8),
		.DEPTH(BDEPTH)
	) u_byte_ram (
		.clk  (clk),
		.en   (byte_en),
		.we   (wr_op),
		.addr (byte_addr),
		.wdata(byte_wdata),
		.rdata(byte_rdata)
	);

	// pipeline stage waiting on read data, then the output register
	logic      valid_s1, last_s1, stored_s1;
	dout_sel_t dsel_s1;
	logic      out_valid_q, last_q, stored_q, out_free;
	logic [15:0] data_out_q, conv;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || out_free;

	always_comb begin
		case (dsel_s1)
			DSEL_WORD:  conv = word_rdata;
			DSEL_BYTE:  conv = {8'd0, byte_rdata};
			DSEL_LAYER: conv = {byte_rdata, byte_rdata};
			DSEL_EDGE:  conv = {15'd0, byte_rdata == BYTE_FULL};
			default:    conv = 16'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				cur_col_q <= (cfg_idx == REG_RECT_LEFT) ? pwdata[8:0] : rect_left_q;
				cur_row_q <= (cfg_idx == REG_RECT_TOP) ? pwdata[8:0] : rect_top_q;
			end else if (acc && !is_direct) begin
				if (rect_empty || wrap) begin
					cur_col_q <= rect_left_q;
					cur_row_q <= rect_top_q;
				end else begin
					cur_col_q <= nx[8:0];
					cur_row_q <= ny[8:0];
				end
			end

			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (out_free) begin
				valid_s1 <= 1'b0;
			end

			if (valid_s1 && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			dsel_s1   <= dsel;
			last_s1   <= !is_direct && (rect_empty || wrap);
			stored_s1 <= wr_op && access && kind_ok;
		end
		if (valid_s1 && out_free) begin
			data_out_q <= conv;
			last_q     <= last_s1;
			stored_q   <= stored_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = data_out_q;
	assign m_tlast  = last_q;
	assign m_tuser  = stored_q;

endmodule

`default_nettype wire

FILE: hw/rtl/crmt_chk.sv
// port-level checker for the clamped rectangle map transfer block
`default_nettype none

`include "assert_macros.svh"

module crmt_chk
	import crmt_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        pready,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic        m_tlast,
	input wire logic [0:0]  m_tuser
);

	logic s_acc;

	assign s_acc = s_tvalid && s_tready;

	`AST_ALWAYS(a_pready_high, clk, arst_n, pready, "config port not ready")
	`AST_IMPLY(a_result_follows, clk, arst_n, s_acc, ##2 m_tvalid, "item gave no result")
	`AST_IMPLY(a_stall_only_when_full, clk, arst_n, !s_tready, m_tvalid, "input stalled with empty output")
	`AST_IMPLY(a_write_has_no_data, clk, arst_n, m_tvalid && m_tuser[0], m_tdata == 16'd0, "stored item carries data")
	`AST_IMPLY(a_out_hold, clk, arst_n, m_tvalid && !m_tready, ##1 (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)), "stalled result changed")

endmodule

bind clamped_rect_map_transfer crmt_chk u_crmt_chk (.*);

`default_nettype wire
